>>> design/wtr_pkg.sv
// ----------------------------------------------------------------------------
// wtr_pkg: shared definitions for the wavelength to RGB color mapper
// Widths, segment constants, divider reciprocals, the gamma table and the
// work item that the front end hands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package wtr_pkg;

  // Gamma table geometry.
  localparam int GAMMA_INDEX_BITS = 10;
  localparam int GAMMA_SIZE       = (1 << GAMMA_INDEX_BITS) + 1;
  localparam int GAMMA_AW         = GAMMA_INDEX_BITS + 1;

  // Field widths.
  localparam int WL_W    = 16;  // wavelength, 6 fraction bits
  localparam int LEVEL_W = 8;   // channel level
  localparam int FRAC_W  = 17;  // Q16 fraction including 1.0
  localparam int DIST_W  = 13;  // offset into a segment, up to 6720
  localparam int ATT_W   = 17;  // attenuation numerator, up to 67193
  localparam int REV_W   = 12;  // remaining violet span, up to 3840
  localparam int NUM_W   = 28;  // dividend of the channel fraction
  localparam int RECIP_W = 32;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int SHIFT_W = 6;

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

  // Segment knees in 1/64 nm.
  localparam logic [WL_W-1:0] NM_380 = WL_W'(380 * 64);
  localparam logic [WL_W-1:0] NM_440 = WL_W'(440 * 64);
  localparam logic [WL_W-1:0] NM_490 = WL_W'(490 * 64);
  localparam logic [WL_W-1:0] NM_510 = WL_W'(510 * 64);
  localparam logic [WL_W-1:0] NM_580 = WL_W'(580 * 64);
  localparam logic [WL_W-1:0] NM_645 = WL_W'(645 * 64);
  localparam logic [WL_W-1:0] NM_750 = WL_W'(750 * 64);

  localparam logic [DIST_W-1:0] VIO_SPAN     = DIST_W'(3840);
  localparam logic [ATT_W-1:0]  ATT_BASE_VIO = ATT_W'(3 * 3840);
  localparam logic [ATT_W-1:0]  ATT_BASE_RED = ATT_W'(3 * 6720);

  // Each fraction round(num * 65536 / den) is rewritten as
  // floor((num << SH + BIAS) / DEN) with the power of two taken out of den.
  localparam int SH_VIO_B    = 7;
  localparam int SH_GRN_RISE = 9;
  localparam int SH_BLU_FALL = 8;
  localparam int SH_RED_RISE = 9;
  localparam int SH_GRN_FALL = 10;
  localparam int SH_DEEP_RED = 9;

  localparam logic [NUM_W-1:0] BIAS_VIO_R    = NUM_W'(1125);
  localparam logic [NUM_W-1:0] BIAS_VIO_B    = NUM_W'(37);
  localparam logic [NUM_W-1:0] BIAS_GRN_RISE = NUM_W'(12);
  localparam logic [NUM_W-1:0] BIAS_BLU_FALL = NUM_W'(2);
  localparam logic [NUM_W-1:0] BIAS_RED_RISE = NUM_W'(17);
  localparam logic [NUM_W-1:0] BIAS_GRN_FALL = NUM_W'(32);
  localparam logic [NUM_W-1:0] BIAS_DEEP_RED = NUM_W'(262);

  localparam int DEN_VIO_B    = 75;
  localparam int DEN_VIO_R    = 2250;
  localparam int DEN_GRN_RISE = 25;
  localparam int DEN_BLU_FALL = 5;
  localparam int DEN_RED_RISE = 35;
  localparam int DEN_GRN_FALL = 65;
  localparam int DEN_DEEP_RED = 525;

  // Reciprocals ceil(2^s / den) with s = 31 + clog2(den). The error term is
  // below den, so the quotient is exact for any dividend below 2^31.
  localparam int SHIFT_VIO_B    = 31 + $clog2(DEN_VIO_B);
  localparam int SHIFT_VIO_R    = 31 + $clog2(DEN_VIO_R);
  localparam int SHIFT_GRN_RISE = 31 + $clog2(DEN_GRN_RISE);
  localparam int SHIFT_BLU_FALL = 31 + $clog2(DEN_BLU_FALL);
  localparam int SHIFT_RED_RISE = 31 + $clog2(DEN_RED_RISE);
  localparam int SHIFT_GRN_FALL = 31 + $clog2(DEN_GRN_FALL);
  localparam int SHIFT_DEEP_RED = 31 + $clog2(DEN_DEEP_RED);

  localparam logic [RECIP_W-1:0] RECIP_VIO_B =
      RECIP_W'(((64'd1 << SHIFT_VIO_B) / DEN_VIO_B) + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_VIO_R =
      RECIP_W'(((64'd1 << SHIFT_VIO_R) / DEN_VIO_R) + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_GRN_RISE =
      RECIP_W'(((64'd1 << SHIFT_GRN_RISE) / DEN_GRN_RISE) + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_BLU_FALL =
      RECIP_W'(((64'd1 << SHIFT_BLU_FALL) / DEN_BLU_FALL) + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_RED_RISE =
      RECIP_W'(((64'd1 << SHIFT_RED_RISE) / DEN_RED_RISE) + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_GRN_FALL =
      RECIP_W'(((64'd1 << SHIFT_GRN_FALL) / DEN_GRN_FALL) + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_DEEP_RED =
      RECIP_W'(((64'd1 << SHIFT_DEEP_RED) / DEN_DEEP_RED) + 64'd1);

  // Work queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CH_ZERO,
    CH_FULL,
    CH_CALC
  } ch_kind_t;

  typedef enum logic [2:0] {
    DIV_VIO_B,
    DIV_VIO_R,
    DIV_GRN_RISE,
    DIV_BLU_FALL,
    DIV_RED_RISE,
    DIV_GRN_FALL,
    DIV_DEEP_RED
  } div_sel_t;

  typedef struct packed {
    ch_kind_t         kind;
    div_sel_t         div;
    logic [NUM_W-1:0] num;
  } chan_op_t;

  typedef struct packed {
    logic     vis;
    chan_op_t red;
    chan_op_t green;
    chan_op_t blue;
  } work_t;

  // True when round(255 * (k / 2^B)^0.8) reaches the given level, compared
  // exactly as (2L-1)^5 * 2^(4B) <= 510^5 * k^4.
  function automatic logic gamma_reaches(input int level, input int k);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] m;
    lhs = 128'd1;
    rhs = 128'd1;
    m   = 128'(2 * level - 1);
    for (int i = 0; i < 5; i++) begin
      lhs = lhs * m;
      rhs = rhs * 128'd510;
    end
    lhs = lhs << (4 * GAMMA_INDEX_BITS);
    for (int i = 0; i < 4; i++) begin
      rhs = rhs * 128'(k);
    end
    return lhs <= rhs;
  endfunction

  function automatic logic [GAMMA_SIZE*LEVEL_W-1:0] build_gamma();
    logic [GAMMA_SIZE*LEVEL_W-1:0] tab;
    int level;
    tab   = '0;
    level = 0;
    for (int k = 0; k < GAMMA_SIZE; k++) begin
      while (level < 255 && gamma_reaches(level + 1, k)) begin
        level++;
      end
      tab[LEVEL_W*k +: LEVEL_W] = LEVEL_W'(level);
    end
    return tab;
  endfunction

  localparam logic [GAMMA_SIZE*LEVEL_W-1:0] GAMMA_TABLE = build_gamma();

endpackage

`default_nettype wire

>>> design/wtr_ram.sv
// ----------------------------------------------------------------------------
// wtr_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// data while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module wtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/wtr_front.sv
// ----------------------------------------------------------------------------
// wtr_front: wavelength classifier
// Finds the spectral segment of each wavelength and builds, per channel, the
// dividend and divisor selection of its intensity fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module wtr_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [wtr_pkg::WL_W-1:0] wavelength_fx,
  output logic                     out_valid,
  input  logic                     out_ready,
  output wtr_pkg::work_t           out_work
);

  typedef enum logic [2:0] {
    SEG_OFF,
    SEG_VIOLET,
    SEG_BLUE,
    SEG_CYAN,
    SEG_GREEN,
    SEG_YELLOW,
    SEG_RED
  } seg_t;

  seg_t                        seg_next;
  logic [wtr_pkg::DIST_W-1:0]  dist_next;
  logic [wtr_pkg::ATT_W-1:0]   att_next;
  logic [wtr_pkg::REV_W-1:0]   rev_next;

  logic                        a_valid;
  seg_t                        a_seg;
  logic [wtr_pkg::DIST_W-1:0]  a_dist;
  logic [wtr_pkg::ATT_W-1:0]   a_att;
  logic [wtr_pkg::REV_W-1:0]   a_rev;

  logic                        b_valid;
  logic                        b_ready;
  wtr_pkg::work_t              b_work;
  wtr_pkg::work_t              b_work_next;

  function automatic wtr_pkg::chan_op_t make_op(input wtr_pkg::ch_kind_t kind,
                                                input wtr_pkg::div_sel_t div,
                                                input logic [wtr_pkg::NUM_W-1:0] num);
    wtr_pkg::chan_op_t op;
    op.kind = kind;
    op.div  = div;
    op.num  = num;
    return op;
  endfunction

  // A wavelength exactly on a knee belongs to the lower segment.
  always_comb begin
    if (wavelength_fx < wtr_pkg::NM_380 || wavelength_fx > wtr_pkg::NM_750) begin
      seg_next = SEG_OFF;
    end else if (wavelength_fx <= wtr_pkg::NM_440) begin
      seg_next = SEG_VIOLET;
    end else if (wavelength_fx <= wtr_pkg::NM_490) begin
      seg_next = SEG_BLUE;
    end else if (wavelength_fx <= wtr_pkg::NM_510) begin
      seg_next = SEG_CYAN;
    end else if (wavelength_fx <= wtr_pkg::NM_580) begin
      seg_next = SEG_GREEN;
    end else if (wavelength_fx <= wtr_pkg::NM_645) begin
      seg_next = SEG_YELLOW;
    end else begin
      seg_next = SEG_RED;
    end
  end

  always_comb begin
    case (seg_next)
      SEG_VIOLET: dist_next = wtr_pkg::DIST_W'(wavelength_fx - wtr_pkg::NM_380);
      SEG_BLUE:   dist_next = wtr_pkg::DIST_W'(wavelength_fx - wtr_pkg::NM_440);
      SEG_CYAN:   dist_next = wtr_pkg::DIST_W'(wtr_pkg::NM_510 - wavelength_fx);
      SEG_GREEN:  dist_next = wtr_pkg::DIST_W'(wavelength_fx - wtr_pkg::NM_510);
      SEG_YELLOW: dist_next = wtr_pkg::DIST_W'(wtr_pkg::NM_645 - wavelength_fx);
      SEG_RED:    dist_next = wtr_pkg::DIST_W'(wtr_pkg::NM_750 - wavelength_fx);
      default:    dist_next = '0;
    endcase
  end

  // Attenuation numerator 3*span + 7*d for both ends of the band.
  always_comb begin
    att_next = wtr_pkg::ATT_W'({dist_next, 3'b000}) - wtr_pkg::ATT_W'(dist_next)
             + ((seg_next == SEG_VIOLET) ? wtr_pkg::ATT_BASE_VIO : wtr_pkg::ATT_BASE_RED);
    rev_next = wtr_pkg::REV_W'(wtr_pkg::VIO_SPAN - dist_next);
  end

  always_comb begin
    b_work_next.vis   = (a_seg != SEG_OFF);
    b_work_next.red   = make_op(wtr_pkg::CH_ZERO, wtr_pkg::DIV_VIO_B, '0);
    b_work_next.green = make_op(wtr_pkg::CH_ZERO, wtr_pkg::DIV_VIO_B, '0);
    b_work_next.blue  = make_op(wtr_pkg::CH_ZERO, wtr_pkg::DIV_VIO_B, '0);
    case (a_seg)
      SEG_VIOLET: begin
        b_work_next.red = make_op(wtr_pkg::CH_CALC, wtr_pkg::DIV_VIO_R,
            wtr_pkg::NUM_W'(a_rev) * wtr_pkg::NUM_W'(a_att) + wtr_pkg::BIAS_VIO_R);
        b_work_next.blue = make_op(wtr_pkg::CH_CALC, wtr_pkg::DIV_VIO_B,
            (wtr_pkg::NUM_W'(a_att) << wtr_pkg::SH_VIO_B) + wtr_pkg::BIAS_VIO_B);
      end
      SEG_BLUE: begin
        b_work_next.green = make_op(wtr_pkg::CH_CALC, wtr_pkg::DIV_GRN_RISE,
            (wtr_pkg::NUM_W'(a_dist) << wtr_pkg::SH_GRN_RISE) + wtr_pkg::BIAS_GRN_RISE);
        b_work_next.blue = make_op(wtr_pkg::CH_FULL, wtr_pkg::DIV_VIO_B, '0);
      end
      SEG_CYAN: begin
        b_work_next.green = make_op(wtr_pkg::CH_FULL, wtr_pkg::DIV_VIO_B, '0);
        b_work_next.blue = make_op(wtr_pkg::CH_CALC, wtr_pkg::DIV_BLU_FALL,
            (wtr_pkg::NUM_W'(a_dist) << wtr_pkg::SH_BLU_FALL) + wtr_pkg::BIAS_BLU_FALL);
      end
      SEG_GREEN: begin
        b_work_next.red = make_op(wtr_pkg::CH_CALC, wtr_pkg::DIV_RED_RISE,
            (wtr_pkg::NUM_W'(a_dist) << wtr_pkg::SH_RED_RISE) + wtr_pkg::BIAS_RED_RISE);
        b_work_next.green = make_op(wtr_pkg::CH_FULL, wtr_pkg::DIV_VIO_B, '0);
      end
      SEG_YELLOW: begin
        b_work_next.red = make_op(wtr_pkg::CH_FULL, wtr_pkg::DIV_VIO_B, '0);
        b_work_next.green = make_op(wtr_pkg::CH_CALC, wtr_pkg::DIV_GRN_FALL,
            (wtr_pkg::NUM_W'(a_dist) << wtr_pkg::SH_GRN_FALL) + wtr_pkg::BIAS_GRN_FALL);
      end
      SEG_RED: begin
        b_work_next.red = make_op(wtr_pkg::CH_CALC, wtr_pkg::DIV_DEEP_RED,
            (wtr_pkg::NUM_W'(a_att) << wtr_pkg::SH_DEEP_RED) + wtr_pkg::BIAS_DEEP_RED);
      end
      default: begin
        b_work_next.vis = 1'b0;
      end
    endcase
  end

  assign b_ready   = !b_valid || out_ready;
  assign in_ready  = !a_valid || b_ready;
  assign out_valid = b_valid;
  assign out_work  = b_work;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_seg  <= seg_next;
      a_dist <= dist_next;
      a_att  <= att_next;
      a_rev  <= rev_next;
    end
    if (a_valid && b_ready) begin
      b_work <= b_work_next;
    end
  end

endmodule

`default_nettype wire

>>> design/wtr_fifo.sv
// ----------------------------------------------------------------------------
// wtr_fifo: work queue between classifier and evaluator
// A short register queue so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module wtr_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wtr_pkg::work_t in_work,
  output logic           out_valid,
  input  logic           out_ready,
  output wtr_pkg::work_t out_work
);

  wtr_pkg::work_t                 mem [wtr_pkg::QUEUE_DEPTH];
  logic [wtr_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [wtr_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [wtr_pkg::QUEUE_CW-1:0]   count;
  logic                           push;
  logic                           pop;

  assign in_ready  = (count != wtr_pkg::QUEUE_CW'(wtr_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_work  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  function automatic logic [wtr_pkg::QUEUE_AW-1:0] wrap_inc(
      input logic [wtr_pkg::QUEUE_AW-1:0] ptr);
    if (ptr == wtr_pkg::QUEUE_AW'(wtr_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_work;
    end
  end

endmodule

`default_nettype wire

>>> design/wtr_back.sv
// ----------------------------------------------------------------------------
// wtr_back: channel evaluator
// Divides each channel dividend by its constant through a reciprocal
// multiply, forms the gamma table index and reads the three level tables.
// Also loads the gamma tables after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wtr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wtr_pkg::work_t              in_work,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wtr_pkg::LEVEL_W-1:0] red_level,
  output logic [wtr_pkg::LEVEL_W-1:0] green_level,
  output logic [wtr_pkg::LEVEL_W-1:0] blue_level,
  output logic                        in_visible_band,
  output logic                        fill_done
);

  typedef struct packed {
    wtr_pkg::ch_kind_t         kind;
    wtr_pkg::div_sel_t         div;
    logic [wtr_pkg::PROD_W-1:0] prod;
  } prod_t;

  logic                          p_valid;
  logic                          p_ready;
  logic                          p_vis;
  prod_t                         p_red;
  prod_t                         p_green;
  prod_t                         p_blue;

  logic                          o_valid;
  logic                          o_ready;
  logic                          o_vis;
  logic                          rd_en;

  logic [wtr_pkg::GAMMA_AW-1:0]  idx_red;
  logic [wtr_pkg::GAMMA_AW-1:0]  idx_green;
  logic [wtr_pkg::GAMMA_AW-1:0]  idx_blue;

  logic [wtr_pkg::GAMMA_AW-1:0]  fill_addr;
  logic [wtr_pkg::LEVEL_W-1:0]   fill_data;
  logic                          fill_we;

  function automatic logic [wtr_pkg::RECIP_W-1:0] recip_of(input wtr_pkg::div_sel_t div);
    case (div)
      wtr_pkg::DIV_VIO_B:    return wtr_pkg::RECIP_VIO_B;
      wtr_pkg::DIV_VIO_R:    return wtr_pkg::RECIP_VIO_R;
      wtr_pkg::DIV_GRN_RISE: return wtr_pkg::RECIP_GRN_RISE;
      wtr_pkg::DIV_BLU_FALL: return wtr_pkg::RECIP_BLU_FALL;
      wtr_pkg::DIV_RED_RISE: return wtr_pkg::RECIP_RED_RISE;
      wtr_pkg::DIV_GRN_FALL: return wtr_pkg::RECIP_GRN_FALL;
      wtr_pkg::DIV_DEEP_RED: return wtr_pkg::RECIP_DEEP_RED;
      default:               return '0;
    endcase
  endfunction

  function automatic logic [wtr_pkg::SHIFT_W-1:0] shift_of(input wtr_pkg::div_sel_t div);
    case (div)
      wtr_pkg::DIV_VIO_B:    return wtr_pkg::SHIFT_W'(wtr_pkg::SHIFT_VIO_B);
      wtr_pkg::DIV_VIO_R:    return wtr_pkg::SHIFT_W'(wtr_pkg::SHIFT_VIO_R);
      wtr_pkg::DIV_GRN_RISE: return wtr_pkg::SHIFT_W'(wtr_pkg::SHIFT_GRN_RISE);
      wtr_pkg::DIV_BLU_FALL: return wtr_pkg::SHIFT_W'(wtr_pkg::SHIFT_BLU_FALL);
      wtr_pkg::DIV_RED_RISE: return wtr_pkg::SHIFT_W'(wtr_pkg::SHIFT_RED_RISE);
      wtr_pkg::DIV_GRN_FALL: return wtr_pkg::SHIFT_W'(wtr_pkg::SHIFT_GRN_FALL);
      wtr_pkg::DIV_DEEP_RED: return wtr_pkg::SHIFT_W'(wtr_pkg::SHIFT_DEEP_RED);
      default:               return '0;
    endcase
  endfunction

  function automatic prod_t chan_product(input wtr_pkg::chan_op_t op);
    prod_t r;
    r.kind = op.kind;
    r.div  = op.div;
    r.prod = wtr_pkg::PROD_W'(op.num) * wtr_pkg::PROD_W'(recip_of(op.div));
    return r;
  endfunction

  // Quotient, clamp to 1.0 and take the top bits of the Q16 fraction.
  function automatic logic [wtr_pkg::GAMMA_AW-1:0] chan_index(input prod_t p);
    logic [wtr_pkg::PROD_W-1:0] q;
    logic [wtr_pkg::FRAC_W-1:0] f;
    q = p.prod >> shift_of(p.div);
    case (p.kind)
      wtr_pkg::CH_FULL: f = wtr_pkg::ONE_Q16;
      wtr_pkg::CH_CALC: begin
        if (q > wtr_pkg::PROD_W'(wtr_pkg::ONE_Q16)) begin
          f = wtr_pkg::ONE_Q16;
        end else begin
          f = q[wtr_pkg::FRAC_W-1:0];
        end
      end
      default: f = '0;
    endcase
    return f[wtr_pkg::FRAC_W-1 -: wtr_pkg::GAMMA_AW];
  endfunction

  assign o_ready  = !o_valid || out_ready;
  assign p_ready  = !p_valid || o_ready;
  assign in_ready = p_ready;
  assign rd_en    = p_valid && o_ready;

  assign idx_red   = chan_index(p_red);
  assign idx_green = chan_index(p_green);
  assign idx_blue  = chan_index(p_blue);

  assign out_valid       = o_valid;
  assign in_visible_band = o_vis;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid <= in_valid;
      end
      if (o_ready) begin
        o_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && p_ready) begin
      p_vis   <= in_work.vis;
      p_red   <= chan_product(in_work.red);
      p_green <= chan_product(in_work.green);
      p_blue  <= chan_product(in_work.blue);
    end
    if (rd_en) begin
      o_vis <= p_vis;
    end
  end

  // Table load: one entry per cycle into all three channel tables.
  assign fill_we   = !fill_done;
  assign fill_data = wtr_pkg::GAMMA_TABLE[wtr_pkg::LEVEL_W*fill_addr +: wtr_pkg::LEVEL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
      fill_done <= 1'b0;
    end else if (!fill_done) begin
      if (fill_addr == wtr_pkg::GAMMA_AW'(wtr_pkg::GAMMA_SIZE - 1)) begin
        fill_done <= 1'b1;
      end else begin
        fill_addr <= fill_addr + 1'b1;
      end
    end
  end

  wtr_ram #(
    .WIDTH (wtr_pkg::LEVEL_W),
    .DEPTH (wtr_pkg::GAMMA_SIZE)
  ) u_ram_red (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_addr),
    .wr_data (fill_data),
    .rd_en   (rd_en),
    .rd_addr (idx_red),
    .rd_data (red_level)
  );

  wtr_ram #(
    .WIDTH (wtr_pkg::LEVEL_W),
    .DEPTH (wtr_pkg::GAMMA_SIZE)
  ) u_ram_green (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_addr),
    .wr_data (fill_data),
    .rd_en   (rd_en),
    .rd_addr (idx_green),
    .rd_data (green_level)
  );

  wtr_ram #(
    .WIDTH (wtr_pkg::LEVEL_W),
    .DEPTH (wtr_pkg::GAMMA_SIZE)
  ) u_ram_blue (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_addr),
    .wr_data (fill_data),
    .rd_en   (rd_en),
    .rd_addr (idx_blue),
    .rd_data (blue_level)
  );

endmodule

`default_nettype wire

>>> design/wavelength_to_rgb.sv
// ----------------------------------------------------------------------------
// wavelength_to_rgb: spectral wavelength to RGB color mapper
// Maps a wavelength in 1/64 nm steps to gamma-corrected 8-bit red, green and
// blue levels, one beat per clock when the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one wavelength beat per clock while the output is not
// stalled and returns one color beat per wavelength, in order. The color
// beat passes through the classifier's two registers, the queue, the
// multiplier register and the table read register, and the first of these
// loads at the edge that accepts its wavelength. Every stage handles one beat
// per cycle: the classifier, the three reciprocal multipliers (one per
// channel) and the three gamma tables, each of which has a dedicated read
// port, so the sustained rate is one beat per clock when the output is not
// stalled. After reset the block loads its gamma tables, one entry per cycle,
// 2^10 + 1 entries in all; s_axis_tready stays low until the load is done.
// The visible band is 380 to 750 nm inclusive; outside it the color is black
// and the band flag is low.
module wavelength_to_rgb (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] wavelength_fx
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] red_level, [15:8] green_level,
                                      // [23:16] blue_level
  output logic        m_axis_tuser    // [0] in_visible_band
);

  logic           front_in_ready;
  logic           front_in_valid;
  logic           front_out_valid;
  logic           front_out_ready;
  wtr_pkg::work_t front_work;

  logic           queue_out_valid;
  logic           queue_out_ready;
  wtr_pkg::work_t queue_work;

  logic           fill_done;
  logic [wtr_pkg::LEVEL_W-1:0] red_level;
  logic [wtr_pkg::LEVEL_W-1:0] green_level;
  logic [wtr_pkg::LEVEL_W-1:0] blue_level;
  logic           in_visible_band;

  // No beat is taken until the gamma tables hold their contents.
  assign s_axis_tready  = front_in_ready && fill_done;
  assign front_in_valid = s_axis_tvalid && fill_done;

  wtr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (front_in_valid),
    .in_ready      (front_in_ready),
    .wavelength_fx (s_axis_tdata),
    .out_valid     (front_out_valid),
    .out_ready     (front_out_ready),
    .out_work      (front_work)
  );

  // The queue lets the classifier keep taking beats while the evaluator
  // waits on a stalled output.
  wtr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_out_valid),
    .in_ready  (front_out_ready),
    .in_work   (front_work),
    .out_valid (queue_out_valid),
    .out_ready (queue_out_ready),
    .out_work  (queue_work)
  );

  // The table read registers form the output register of the block.
  wtr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (queue_out_valid),
    .in_ready        (queue_out_ready),
    .in_work         (queue_work),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .red_level       (red_level),
    .green_level     (green_level),
    .blue_level      (blue_level),
    .in_visible_band (in_visible_band),
    .fill_done       (fill_done)
  );

  assign m_axis_tdata = {blue_level, green_level, red_level};
  assign m_axis_tuser = in_visible_band;

endmodule

`default_nettype wire
